### hdl/lfo_modulated_ladder_filter_top_assert.svh
// Assertion macros for the LFO-swept ladder filter top level.
// Used by hdl/lfo_modulated_ladder_filter_top.sv; expects clk and rst_n in scope.
`ifndef LFO_MODULATED_LADDER_FILTER_TOP_ASSERT_SVH
`define LFO_MODULATED_LADDER_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define LMLF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lmlf_pkg.sv
// Shared types, constants and tables for the LFO-swept ladder filter.
// No dependencies; imported by all modules of the block.
`default_nettype none

package lmlf_pkg;

    localparam int SAMPLE_RATE_DEF = 48000;
    localparam int LADDER_POLES    = 4;
    localparam int WC_W            = 30;
    localparam int SAMPLE_W        = 24;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [29:0] PI_Q28     = 30'd843314857;
    localparam logic [30:0] FMIN_Q16   = 31'd1310720;
    localparam logic [30:0] FMAX_Q16   = 31'd1310720000;

    localparam logic [14:0] RST_CUTOFF = 15'd2000;
    localparam logic [15:0] RST_RES    = 16'd19661;
    localparam logic [31:0] RST_STEP   = 32'd89478;
    localparam logic [1:0]  RST_MODE   = 2'd0;
    localparam logic [16:0] RST_DEPTH  = 17'd32768;
    localparam logic [16:0] RST_DRIVE  = 17'd13107;
    localparam logic [16:0] RST_MIX    = 17'd65536;
    localparam logic [14:0] RST_OGAIN  = 15'd16384;

    typedef enum logic [2:0] {
        REG_CUTOFF, REG_RES, REG_STEP, REG_MODE,
        REG_DEPTH, REG_DRIVE, REG_MIX, REG_OGAIN
    } reg_idx_t;

    localparam logic [15:0] SIN_TAB [17] = '{
        16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12540, 16'd15447, 16'd18205,
        16'd20788, 16'd23170, 16'd25330, 16'd27246, 16'd28899, 16'd30274,
        16'd31357, 16'd32138, 16'd32610, 16'd32768
    };

    localparam logic [17:0] EXP2_TAB [17] = '{
        18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
        18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    localparam logic [16:0] TANH_TAB [17] = '{
        17'd0, 17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593,
        17'd59320, 17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65003,
        17'd65212, 17'd65339, 17'd65417, 17'd65464, 17'd65492
    };

    typedef struct packed {
        logic [14:0] cutoff;
        logic [31:0] step;
        logic [1:0]  mode;
        logic [16:0] depth;
    } lfo_cfg_t;

    typedef struct packed {
        logic [WC_W-1:0] wc;
        logic [15:0]     res;
        logic [18:0]     gain;
        logic [16:0]     mix;
        logic [14:0]     ogain;
    } lane_cfg_t;

    // tanh of a Q8.28 value, table over 0..4 with linear interpolation
    function automatic logic signed [31:0] tanh_q28(input logic signed [35:0] x);
        logic [35:0] a;
        logic [3:0]  idx;
        logic [25:0] fr;
        logic [16:0] diff;
        logic [41:0] prod;
        logic [31:0] v;
        a    = x[35] ? 36'(-x) : 36'(x);
        idx  = a[29:26];
        fr   = a[25:0];
        diff = TANH_TAB[{1'b0, idx} + 5'd1] - TANH_TAB[idx];
        prod = {25'b0, diff} * {16'b0, fr};
        if (a[35:30] != 6'd0)
            v = {3'b0, TANH_TAB[16], 12'b0};
        else
            v = {3'b0, TANH_TAB[idx], 12'b0} + 32'(prod >> 14);
        return x[35] ? -$signed(v) : $signed(v);
    endfunction

endpackage

`default_nettype wire

### hdl/lmlf_lfo_coef.sv
// Shared LFO and cutoff coefficient unit: phase, wave, exp2 sweep, clamp,
// and a reciprocal divide by the sample rate. Depends on lmlf_pkg.
`default_nettype none

module lmlf_lfo_coef
    import lmlf_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire lfo_cfg_t        cfg,
    output logic                 done,
    output logic [WC_W-1:0]      wc
);

    // wc = floor(floor(f * 2pi / 2^16) / rate); estimate by reciprocal, then correct
    localparam int          RSHIFT  = 31 + $clog2(SAMPLE_RATE_HZ);
    localparam logic [63:0] RECIP   = (64'd1 << RSHIFT) / 64'(SAMPLE_RATE_HZ);
    localparam logic [31:0] RECIP_C = RECIP[31:0];
    localparam logic [17:0] RATE_C  = 18'(SAMPLE_RATE_HZ);
    localparam int          Q_SH    = RSHIFT - 14;

    typedef enum logic [3:0] {
        C_IDLE, C_PHASE, C_WAVE, C_EXP, C_MANT, C_FREQ, C_MUL, C_REC, C_PRD, C_FIX, C_CAP
    } cstate_t;

    cstate_t                  state_reg, state_next;
    logic [31:0]              phase_reg, phase_next;
    logic                     done_reg, done_next;

    logic signed [17:0]       lfo_reg, lfo_next;
    logic signed [19:0]       e_reg, e_next;
    logic [17:0]              mant_reg, mant_next;
    logic [30:0]              f_reg, f_next;
    logic [61:0]              x_reg, x_next;
    logic [33:0]              q_reg, q_next;
    logic [23:0]              r_reg, r_next;
    logic [WC_W-1:0]          wc_reg, wc_next;

    logic [1:0]               quad;
    logic [30:0]              pos, q;
    logic [3:0]               sidx;
    logic [15:0]              sdiff, sv;
    logic [27:0]              sprod;
    logic signed [17:0]       sine, tri_w, wave;
    logic [31:0]              d;
    logic signed [18:0]       tri_full;
    logic signed [35:0]       eprod;
    logic [3:0]               xidx;
    logic [17:0]              xdiff;
    logic [29:0]              xprod;
    logic [32:0]              fm;
    logic [36:0]              fsh;
    logic signed [3:0]        ei;
    logic [63:0]              rprod;
    logic [51:0]              qprod;
    logic [51:0]              rdiff;

    always_comb
    begin
        // sine from the quarter-wave table
        quad  = phase_reg[31:30];
        pos   = {1'b0, phase_reg[29:0]};
        q     = quad[0] ? (31'h40000000 - pos) : pos;
        sidx  = q[29:26];
        sdiff = SIN_TAB[{1'b0, sidx} + 5'd1] - SIN_TAB[sidx];
        sprod = {12'b0, sdiff} * {12'b0, q[25:10]};
        sv    = q[30] ? SIN_TAB[16] : SIN_TAB[sidx] + 16'(sprod >> 16);
        sine  = quad[1] ? -$signed({1'b0, sv, 1'b0}) : $signed({1'b0, sv, 1'b0});

        d        = phase_reg[31] ? (phase_reg - 32'h80000000)
                                 : (32'h80000000 - phase_reg);
        tri_full = 19'sd65536 - $signed({1'b0, d[31:16], 2'b0});
        tri_w    = 18'(tri_full);
        wave     = cfg.mode[0] ? tri_w : sine;
        if (cfg.mode[1])
            wave = 18'((19'(wave) + 19'sd65536) >>> 1);

        eprod = $signed({1'b0, cfg.depth}) * lfo_reg;

        xidx  = e_reg[15:12];
        xdiff = EXP2_TAB[{1'b0, xidx} + 5'd1] - EXP2_TAB[xidx];
        xprod = {12'b0, xdiff} * {18'b0, e_reg[11:0]};

        ei = e_reg[19:16];
        fm = {18'b0, cfg.cutoff} * {15'b0, mant_reg};
        if (ei[3])
            fsh = 37'(fm >> 3'(-ei));
        else
            fsh = 37'(fm) << ei[2:0];

        rprod = {32'b0, x_reg[61:30]} * {32'b0, RECIP_C};
        qprod = {18'b0, q_reg} * {34'b0, RATE_C};
        rdiff = {6'b0, x_reg[61:16]} - qprod;
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        lfo_next   = lfo_reg;
        e_next     = e_reg;
        mant_next  = mant_reg;
        f_next     = f_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        wc_next    = wc_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                    state_next = C_PHASE;
            end
            C_PHASE:
            begin
                phase_next = phase_reg + cfg.step;
                state_next = C_WAVE;
            end
            C_WAVE:
            begin
                lfo_next   = wave;
                state_next = C_EXP;
            end
            C_EXP:
            begin
                e_next     = 20'(eprod >>> 14);
                state_next = C_MANT;
            end
            C_MANT:
            begin
                mant_next  = EXP2_TAB[xidx] + 18'(xprod >> 12);
                state_next = C_FREQ;
            end
            C_FREQ:
            begin
                if (fsh < 37'(FMIN_Q16))
                    f_next = FMIN_Q16;
                else if (fsh > 37'(FMAX_Q16))
                    f_next = FMAX_Q16;
                else
                    f_next = fsh[30:0];
                state_next = C_MUL;
            end
            C_MUL:
            begin
                x_next     = {31'b0, f_reg} * {31'b0, TWO_PI_Q28};
                state_next = C_REC;
            end
            C_REC:
            begin
                q_next     = 34'(rprod >> Q_SH);
                state_next = C_PRD;
            end
            C_PRD:
            begin
                r_next     = rdiff[23:0];
                state_next = C_FIX;
            end
            C_FIX:
            begin
                if (r_reg >= {6'b0, RATE_C})
                begin
                    r_next = r_reg - {6'b0, RATE_C};
                    q_next = q_reg + 34'd1;
                end
                else
                    state_next = C_CAP;
            end
            C_CAP:
            begin
                wc_next    = (q_reg > {4'b0, PI_Q28}) ? PI_Q28 : q_reg[WC_W-1:0];
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lfo_reg  <= lfo_next;
        e_reg    <= e_next;
        mant_reg <= mant_next;
        f_reg    <= f_next;
        x_reg    <= x_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        wc_reg   <= wc_next;
    end

    assign done = done_reg;
    assign wc   = wc_reg;

endmodule

`default_nettype wire

### hdl/lmlf_lane.sv
// One channel lane: drive, resonance feedback, four-stage tanh ladder,
// dry/wet mix and output gain, stepped by a small sequencer. Depends on lmlf_pkg.
`default_nettype none

module lmlf_lane
    import lmlf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire lane_cfg_t                  cfg,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            done,
    output logic signed [SAMPLE_W-1:0]      result
);

    localparam int K_W = $clog2(LADDER_POLES);

    typedef enum logic [3:0] {
        L_IDLE, L_PRE, L_T1, L_T2, L_TS, L_MUL, L_UPD, L_TN, L_MIX, L_OUT
    } lstate_t;

    lstate_t                    state_reg, state_next;
    logic [K_W-1:0]             k_reg, k_next;
    logic                       done_reg, done_next;
    logic signed [31:0]         st_reg [LADDER_POLES];
    logic signed [31:0]         st_next [LADDER_POLES];

    logic signed [32:0]         pre_reg, pre_next;
    logic signed [34:0]         fb_reg, fb_next;
    logic signed [31:0]         t_reg, t_next;
    logic signed [31:0]         ts_reg, ts_next;
    logic signed [34:0]         dq_reg, dq_next;
    logic signed [33:0]         mixed_reg, mixed_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    logic signed [28:0]         in28;
    logic signed [48:0]         p_pre, p_fb;
    logic signed [32:0]         delta;
    logic signed [63:0]         p_d;
    logic signed [34:0]         sum;
    logic signed [49:0]         p_mix;
    logic signed [49:0]         p_g;
    logic signed [30:0]         o;

    always_comb
    begin
        in28  = {sample, 5'b0};
        p_pre = in28 * $signed({1'b0, cfg.gain});
        p_fb  = st_reg[LADDER_POLES-1] * $signed({1'b0, cfg.res});
        delta = 33'(t_reg) - 33'(ts_reg);
        p_d   = delta * $signed({1'b0, cfg.wc});
        sum   = 35'(st_reg[k_reg]) + dq_reg;
        p_mix = in28 * $signed({1'b0, 17'(ONE_Q16 - cfg.mix)})
              + st_reg[LADDER_POLES-1] * $signed({1'b0, cfg.mix});
        p_g   = mixed_reg * $signed({1'b0, cfg.ogain});
        o     = 31'((36'(p_g >>> 14) + 36'sd16) >>> 5);
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        pre_next   = pre_reg;
        fb_next    = fb_reg;
        t_next     = t_reg;
        ts_next    = ts_reg;
        dq_next    = dq_reg;
        mixed_next = mixed_reg;
        out_next   = out_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                    state_next = L_PRE;
            end
            L_PRE:
            begin
                pre_next   = 33'(p_pre >>> 16);
                fb_next    = 35'(p_fb >>> 14);
                state_next = L_T1;
            end
            L_T1:
            begin
                t_next     = tanh_q28(36'(pre_reg) - 36'(fb_reg));
                state_next = L_T2;
            end
            L_T2:
            begin
                t_next     = tanh_q28(36'(t_reg));
                k_next     = '0;
                state_next = L_TS;
            end
            L_TS:
            begin
                ts_next    = tanh_q28(36'(st_reg[k_reg]));
                state_next = L_MUL;
            end
            L_MUL:
            begin
                dq_next    = 35'(p_d >>> 28);
                state_next = L_UPD;
            end
            L_UPD:
            begin
                if (sum > 35'sd2147483647)
                    st_next[k_reg] = 32'sh7FFFFFFF;
                else if (sum < -35'sd2147483648)
                    st_next[k_reg] = 32'sh80000000;
                else
                    st_next[k_reg] = 32'(sum);
                state_next = L_TN;
            end
            L_TN:
            begin
                t_next = tanh_q28(36'(st_reg[k_reg]));
                k_next = k_reg + 1'b1;
                if (k_reg == K_W'(LADDER_POLES - 1))
                    state_next = L_MIX;
                else
                    state_next = L_TS;
            end
            L_MIX:
            begin
                mixed_next = 34'(p_mix >>> 16);
                state_next = L_OUT;
            end
            L_OUT:
            begin
                if (o > 31'sd8388607)
                    out_next = 24'sh7FFFFF;
                else if (o < -31'sd8388608)
                    out_next = 24'sh800000;
                else
                    out_next = 24'(o);
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < LADDER_POLES; i++)
                st_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg   <= pre_next;
        fb_reg    <= fb_next;
        t_reg     <= t_next;
        ts_reg    <= ts_next;
        dq_reg    <= dq_next;
        mixed_reg <= mixed_next;
        out_reg   <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

### hdl/lfo_modulated_ladder_filter_top.sv
// Each input transfer passes through the coefficient unit, whose divide adds a
// correction step whenever the remainder is still at least the sample rate, then
// through both lanes, and is then handed into the output register.
// One stereo pair is processed at a time: the next input transfer waits for the
// output register, which takes a new result when empty or not stalled.
// Reset clears the LFO phase, the ladder stages and all control state;
// configuration registers return to their defaults.
`default_nettype none

module lfo_modulated_ladder_filter_top
    import lmlf_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [4:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] left_in,
    input  wire logic signed [SAMPLE_W-1:0] right_in,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      left_out,
    output logic signed [SAMPLE_W-1:0]      right_out
);

    typedef enum logic [1:0] {T_IDLE, T_COEF, T_LANE, T_OUT} tstate_t;

    logic [14:0] cutoff_reg;
    logic [15:0] res_reg;
    logic [31:0] step_reg;
    logic [1:0]  mode_reg;
    logic [16:0] depth_reg, drive_reg, mix_reg;
    logic [14:0] ogain_reg;

    tstate_t                    state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] left_s_reg, right_s_reg;
    logic signed [SAMPLE_W-1:0] left_o_reg, right_o_reg;

    logic                       cfg_wr, accept, load;
    reg_idx_t                   widx, ridx;
    logic [16:0]                depth_c, drive_c, mix_c;
    lfo_cfg_t                   lfo_cfg;
    lane_cfg_t                  lane_cfg;
    logic                       coef_done, lane_done_l, lane_done_r;
    logic [WC_W-1:0]            wc;
    logic signed [SAMPLE_W-1:0] res_l, res_r;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign ridx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= RST_CUTOFF;
            res_reg    <= RST_RES;
            step_reg   <= RST_STEP;
            mode_reg   <= RST_MODE;
            depth_reg  <= RST_DEPTH;
            drive_reg  <= RST_DRIVE;
            mix_reg    <= RST_MIX;
            ogain_reg  <= RST_OGAIN;
        end
        else if (cfg_wr)
        begin
            case (widx)
                REG_CUTOFF: cutoff_reg <= pwdata[14:0];
                REG_RES:    res_reg    <= pwdata[15:0];
                REG_STEP:   step_reg   <= pwdata;
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_DEPTH:  depth_reg  <= pwdata[16:0];
                REG_DRIVE:  drive_reg  <= pwdata[16:0];
                REG_MIX:    mix_reg    <= pwdata[16:0];
                REG_OGAIN:  ogain_reg  <= pwdata[14:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_CUTOFF: prdata = {17'b0, cutoff_reg};
            REG_RES:    prdata = {16'b0, res_reg};
            REG_STEP:   prdata = step_reg;
            REG_MODE:   prdata = {30'b0, mode_reg};
            REG_DEPTH:  prdata = {15'b0, depth_reg};
            REG_DRIVE:  prdata = {15'b0, drive_reg};
            REG_MIX:    prdata = {15'b0, mix_reg};
            REG_OGAIN:  prdata = {17'b0, ogain_reg};
            default:    prdata = '0;
        endcase
    end

    assign depth_c = (depth_reg > ONE_Q16) ? ONE_Q16 : depth_reg;
    assign drive_c = (drive_reg > ONE_Q16) ? ONE_Q16 : drive_reg;
    assign mix_c   = (mix_reg > ONE_Q16) ? ONE_Q16 : mix_reg;

    assign lfo_cfg = '{cutoff: cutoff_reg, step: step_reg, mode: mode_reg,
                       depth: depth_c};
    assign lane_cfg = '{wc: wc, res: res_reg,
                        gain: 19'(ONE_Q16) + 19'(drive_c) * 19'd3,
                        mix: mix_c, ogain: ogain_reg};

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != T_IDLE);
    assign load     = (state_reg == T_OUT) && (!out_valid_reg || !out_stall);

    lmlf_lfo_coef #(
        .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
    ) u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .cfg   (lfo_cfg),
        .done  (coef_done),
        .wc    (wc)
    );

    lmlf_lane u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (coef_done),
        .cfg    (lane_cfg),
        .sample (left_s_reg),
        .done   (lane_done_l),
        .result (res_l)
    );

    lmlf_lane u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (coef_done),
        .cfg    (lane_cfg),
        .sample (right_s_reg),
        .done   (lane_done_r),
        .result (res_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (accept) state_next = T_COEF;
            T_COEF:  if (coef_done) state_next = T_LANE;
            T_LANE:  if (lane_done_l) state_next = T_OUT;
            T_OUT:   if (load) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_s_reg  <= left_in;
            right_s_reg <= right_in;
        end
        if (load)
        begin
            left_o_reg  <= res_l;
            right_o_reg <= res_r;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_o_reg;
    assign right_out = right_o_reg;

`include "lfo_modulated_ladder_filter_top_assert.svh"

    `LMLF_ASSERT_IMPLY(a_coef_done_state, coef_done, state_reg == T_COEF, "coef done outside COEF")
    `LMLF_ASSERT_IMPLY(a_lanes_in_step, lane_done_l, lane_done_r && state_reg == T_LANE, "lanes out of step")
    `LMLF_ASSERT_NEXT(a_busy_after_accept, accept, in_stall && !coef_done, "not busy after transfer")

endmodule

`default_nettype wire
